[hw/rtl/deadline_ready_queue_assert.svh]
// assertion macros for the deadline ready queue
`ifndef DEADLINE_READY_QUEUE_ASSERT_SVH
`define DEADLINE_READY_QUEUE_ASSERT_SVH

// property that must hold in the same cycle
`define DLRQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// consequent that must hold in the cycle after the antecedent
`define DLRQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/dlrq_pkg.sv]
// types and constants of the deadline ready queue
package dlrq_pkg;

    // fixed field widths
    localparam int DL_W     = 32;
    localparam int JOB_IN_W = 8;
    localparam int CMD_W    = 2;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_DROP  = 2'd2,
        CMD_QUERY = 2'd3
    } t_cmd;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_WALK = 4'b0010,
        ST_INS  = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

endpackage

[hw/rtl/deadline_ready_queue.sv]
// earliest-deadline-first ready queue with a sequential walk over one entry memory
`include "deadline_ready_queue_assert.svh"

// A command is taken when start is high and busy is low; its single result
// (o_valid for one cycle) cannot be held off, so the receiver never stalls.
// Entries live in a memory with one registered read port and one write port,
// sorted by ascending 32-bit unsigned deadline, equal deadlines in arrival
// order. One walk reads one entry per cycle and moves it. A query, a refused
// push, a pop on one or no entry and a drop on an empty queue go straight
// to the result; a pop walks over the entries behind the head and a drop
// over every entry; a push into an empty queue writes the new entry directly;
// any other push walks down from the tail, moving each entry with a later
// deadline one place back, and then writes the new entry. The next word can
// be taken in the cycle after the result.
module deadline_ready_queue #(
    parameter int DEPTH    = 16,
    parameter int JOB_BITS = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [dlrq_pkg::CMD_W-1:0]            i_command,
    input  logic [dlrq_pkg::JOB_IN_W-1:0]         i_job_number,
    input  logic [dlrq_pkg::DL_W-1:0]             i_deadline,
    input  logic                                  i_high_crit,
    output logic                                  o_valid,
    output logic                                  o_head_valid,
    output logic [JOB_BITS-1:0]                   o_head_job,
    output logic [$clog2(DEPTH+1)-1:0]            o_entry_count,
    output logic                                  o_refused
);
    import dlrq_pkg::*;

    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int JMIN_W = (JOB_BITS < JOB_IN_W) ? JOB_BITS : JOB_IN_W;

    // entry memory
    logic [DL_W-1:0]     mem_dl  [DEPTH];
    logic [JOB_BITS-1:0] mem_job [DEPTH];
    logic                mem_hi  [DEPTH];

    // control registers
    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_fill, n_fill;
    logic               r_refused, n_refused;
    logic [IDX_W-1:0]   r_rd_idx, n_rd_idx;
    logic               r_rd_on, n_rd_on;
    logic               r_pend, n_pend;
    logic [IDX_W-1:0]   r_pend_idx, n_pend_idx;
    logic [CNT_W-1:0]   r_wr, n_wr;
    logic [IDX_W-1:0]   r_ins_pos, n_ins_pos;

    // payload registers
    t_cmd               r_cmd, n_cmd;
    logic [JOB_BITS-1:0] r_job, n_job;
    logic [DL_W-1:0]    r_dl, n_dl;
    logic               r_hi, n_hi;
    logic [JOB_BITS-1:0] r_head_job;
    logic [DL_W-1:0]    r_rd_dl;
    logic [JOB_BITS-1:0] r_rd_job;
    logic               r_rd_hi;

    // memory port controls
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_wa;
    logic [DL_W-1:0]    mem_wd_dl;
    logic [JOB_BITS-1:0] mem_wd_job;
    logic               mem_wd_hi;

    logic [JOB_BITS-1:0] job_in;
    logic [CNT_W-1:0]    fill_m1;
    logic [IDX_W-1:0]    last_idx;
    logic                accept;

    assign accept   = start && (r_state == ST_IDLE);
    assign busy     = (r_state != ST_IDLE);
    assign job_in   = JOB_BITS'(i_job_number[JMIN_W-1:0]);
    assign fill_m1  = r_fill - CNT_W'(1);
    assign last_idx = fill_m1[IDX_W-1:0];

    // sequencer and walk
    always_comb begin
        n_state    = r_state;
        n_fill     = r_fill;
        n_refused  = r_refused;
        n_rd_idx   = r_rd_idx;
        n_rd_on    = r_rd_on;
        n_pend     = 1'b0;
        n_pend_idx = r_pend_idx;
        n_wr       = r_wr;
        n_ins_pos  = r_ins_pos;
        n_cmd      = r_cmd;
        n_job      = r_job;
        n_dl       = r_dl;
        n_hi       = r_hi;
        rd_en      = 1'b0;
        rd_addr    = r_rd_idx;
        mem_we     = 1'b0;
        mem_wa     = r_ins_pos;
        mem_wd_dl  = r_rd_dl;
        mem_wd_job = r_rd_job;
        mem_wd_hi  = r_rd_hi;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_cmd     = t_cmd'(i_command);
                    n_job     = job_in;
                    n_dl      = i_deadline;
                    n_hi      = i_high_crit;
                    n_refused = 1'b0;
                    n_wr      = '0;
                    n_state   = ST_DONE;
                    case (t_cmd'(i_command))
                        CMD_PUSH: begin
                            if (r_fill == CNT_W'(DEPTH)) begin
                                n_refused = 1'b1;
                            end else if (r_fill == '0) begin
                                n_ins_pos = '0;
                                n_state   = ST_INS;
                            end else begin
                                n_rd_idx = last_idx;
                                n_rd_on  = 1'b1;
                                n_state  = ST_WALK;
                            end
                        end
                        CMD_POP: begin
                            if (r_fill == CNT_W'(1)) begin
                                n_fill = '0;
                            end else if (r_fill != '0) begin
                                n_rd_idx = IDX_W'(1);
                                n_rd_on  = 1'b1;
                                n_state  = ST_WALK;
                            end
                        end
                        CMD_DROP: begin
                            if (r_fill != '0) begin
                                n_rd_idx = '0;
                                n_rd_on  = 1'b1;
                                n_state  = ST_WALK;
                            end
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_WALK: begin
                // issue the next read
                rd_en      = r_rd_on;
                n_pend     = r_rd_on;
                n_pend_idx = r_rd_idx;
                if (r_rd_on) begin
                    if (r_cmd == CMD_PUSH) begin
                        if (r_rd_idx == '0) begin
                            n_rd_on = 1'b0;
                        end else begin
                            n_rd_idx = r_rd_idx - IDX_W'(1);
                        end
                    end else begin
                        if (r_rd_idx == last_idx) begin
                            n_rd_on = 1'b0;
                        end else begin
                            n_rd_idx = r_rd_idx + IDX_W'(1);
                        end
                    end
                end
                // handle the word read last cycle
                if (r_pend) begin
                    case (r_cmd)
                        CMD_PUSH: begin
                            if (r_rd_dl > r_dl) begin
                                // later deadline moves one place back
                                mem_we = 1'b1;
                                mem_wa = r_pend_idx + IDX_W'(1);
                                if (r_pend_idx == '0) begin
                                    n_ins_pos = '0;
                                    n_state   = ST_INS;
                                    n_rd_on   = 1'b0;
                                    n_pend    = 1'b0;
                                end
                            end else begin
                                n_ins_pos = r_pend_idx + IDX_W'(1);
                                n_state   = ST_INS;
                                n_rd_on   = 1'b0;
                                n_pend    = 1'b0;
                            end
                        end
                        CMD_POP: begin
                            mem_we = 1'b1;
                            mem_wa = r_pend_idx - IDX_W'(1);
                            if (r_pend_idx == last_idx) begin
                                n_fill  = fill_m1;
                                n_state = ST_DONE;
                                n_pend  = 1'b0;
                            end
                        end
                        CMD_DROP: begin
                            // keep high-criticality entries, packed in order
                            if (r_rd_hi) begin
                                mem_we = 1'b1;
                                mem_wa = r_wr[IDX_W-1:0];
                                n_wr   = r_wr + CNT_W'(1);
                            end
                            if (r_pend_idx == last_idx) begin
                                n_fill  = r_wr + CNT_W'(r_rd_hi);
                                n_state = ST_DONE;
                                n_pend  = 1'b0;
                            end
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_INS: begin
                // place the new entry
                mem_we     = 1'b1;
                mem_wa     = r_ins_pos;
                mem_wd_dl  = r_dl;
                mem_wd_job = r_job;
                mem_wd_hi  = r_hi;
                n_fill     = r_fill + CNT_W'(1);
                n_state    = ST_DONE;
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_fill     <= '0;
            r_refused  <= 1'b0;
            r_rd_idx   <= '0;
            r_rd_on    <= 1'b0;
            r_pend     <= 1'b0;
            r_pend_idx <= '0;
            r_wr       <= '0;
            r_ins_pos  <= '0;
        end else begin
            r_state    <= n_state;
            r_fill     <= n_fill;
            r_refused  <= n_refused;
            r_rd_idx   <= n_rd_idx;
            r_rd_on    <= n_rd_on;
            r_pend     <= n_pend;
            r_pend_idx <= n_pend_idx;
            r_wr       <= n_wr;
            r_ins_pos  <= n_ins_pos;
        end
    end

    // command word and head copy
    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_job <= n_job;
        r_dl  <= n_dl;
        r_hi  <= n_hi;
        if (mem_we && (mem_wa == '0)) begin
            r_head_job <= mem_wd_job;
        end
    end

    // entry memory, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_dl[mem_wa]  <= mem_wd_dl;
            mem_job[mem_wa] <= mem_wd_job;
            mem_hi[mem_wa]  <= mem_wd_hi;
        end
        if (rd_en) begin
            r_rd_dl  <= mem_dl[rd_addr];
            r_rd_job <= mem_job[rd_addr];
            r_rd_hi  <= mem_hi[rd_addr];
        end
    end

    // result word
    assign o_valid       = (r_state == ST_DONE);
    assign o_head_valid  = (r_fill != '0);
    assign o_head_job    = (r_fill != '0) ? r_head_job : '0;
    assign o_entry_count = r_fill;
    assign o_refused     = r_refused;

    // checks
    `DLRQ_ASSERT(a_fill_bound, r_fill <= CNT_W'(DEPTH), "fill count above depth")
    `DLRQ_ASSERT(a_head_vs_count, o_head_valid == (o_entry_count != '0), "head valid off count")
    `DLRQ_ASSERT(a_refused_full, !(o_valid && o_refused) || (r_fill == CNT_W'(DEPTH)), "early refusal")
    `DLRQ_ASSERT(a_no_idle_write, (r_state != ST_IDLE) || !mem_we, "memory written while idle")
    `DLRQ_ASSERT_NEXT(a_busy_after_start, start && !busy, busy, "not busy after accept")

endmodule
